/* design/sul_pkg.sv */
// ----------------------------------------------------------------------------
// sul_pkg
// Shared types and constants for the sort-unique list core.
// ----------------------------------------------------------------------------
package sul_pkg;

  // number of cells in the insertion chain
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ValueW   = 32;

  typedef logic [ValueW-1:0] value_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;   // place the broadcast value into the sorted chain
    logic shift;    // move every cell one place toward the head
  } chain_cmd_t;

endpackage

/* design/sort_unique_list_core.sv */
// ----------------------------------------------------------------------------
// sort_unique_list_core
// Sorts a list of 32-bit identifiers and emits the distinct ones ascending.
// ----------------------------------------------------------------------------
// Identifiers are taken one per cycle while loading; each is inserted into a
// chain of CAPACITY cells kept in ascending order. Items beyond CAPACITY are
// dropped and flag overflow on every result of that list. After the item
// marked last, input is stalled while the chain shifts toward its head one
// cell per cycle (when the output is not stalled), and equal values leave as
// a single result. The final result carries last_res.
module sort_unique_list_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sul_pkg::ValueW-1:0]    value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sul_pkg::ValueW-1:0]    value_res_o,
  output logic                          last_res_o,
  output logic                          overflow_o
);

  sul_pkg::chain_cmd_t cmd;
  logic                ins   [sul_pkg::CAPACITY];
  logic                vld   [sul_pkg::CAPACITY];
  sul_pkg::value_t     val   [sul_pkg::CAPACITY];

  for (genvar i = 0; i < sul_pkg::CAPACITY; i++) begin : g_cell
    logic            prev_ins, prev_vld, next_vld;
    sul_pkg::value_t prev_val, next_val;

    if (i == 0) begin : g_head
      assign prev_ins = 1'b0;
      assign prev_vld = 1'b1;
      assign prev_val = '0;
    end else begin : g_body
      assign prev_ins = ins[i-1];
      assign prev_vld = vld[i-1];
      assign prev_val = val[i-1];
    end

    if (i == sul_pkg::CAPACITY - 1) begin : g_tail
      assign next_vld = 1'b0;
      assign next_val = '0;
    end else begin : g_inner
      assign next_vld = vld[i+1];
      assign next_val = val[i+1];
    end

    sul_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .ins_value_i  (value_i),
      .prev_ins_i   (prev_ins),
      .prev_valid_i (prev_vld),
      .prev_value_i (prev_val),
      .next_valid_i (next_vld),
      .next_value_i (next_val),
      .ins_o        (ins[i]),
      .valid_o      (vld[i]),
      .value_o      (val[i])
    );
  end

  sul_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .last_i         (last_i),
    .in_stall_o     (in_stall_o),
    .full_i         (vld[sul_pkg::CAPACITY-1]),
    .head_valid_i   (vld[0]),
    .head_value_i   (val[0]),
    .second_valid_i (vld[1]),
    .second_value_i (val[1]),
    .cmd_o          (cmd),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_res_o    (value_res_o),
    .last_res_o     (last_res_o),
    .overflow_o     (overflow_o)
  );

endmodule

/* design/sul_cell.sv */
// ----------------------------------------------------------------------------
// sul_cell
// One cell of the sorted insertion chain: holds a value and a valid bit.
// ----------------------------------------------------------------------------
module sul_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sul_pkg::chain_cmd_t cmd_i,
  input  sul_pkg::value_t     ins_value_i,
  // neighbor toward the head
  input  logic                prev_ins_i,
  input  logic                prev_valid_i,
  input  sul_pkg::value_t     prev_value_i,
  // neighbor toward the tail
  input  logic                next_valid_i,
  input  sul_pkg::value_t     next_value_i,
  output logic                ins_o,
  output logic                valid_o,
  output sul_pkg::value_t     value_o
);

  logic            valid_q, valid_d;
  sul_pkg::value_t value_q, value_d;

  // insertion point lies here or further toward the head
  assign ins_o   = !valid_q || (value_q > ins_value_i);
  assign valid_o = valid_q;
  assign value_o = value_q;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (cmd_i.insert) begin
      valid_d = valid_q || prev_valid_i;
      if (prev_ins_i) begin
        value_d = prev_value_i;
      end else if (ins_o) begin
        value_d = ins_value_i;
      end
    end else if (cmd_i.shift) begin
      valid_d = next_valid_i;
      value_d = next_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

/* design/sul_ctrl.sv */
// ----------------------------------------------------------------------------
// sul_ctrl
// Load/drain sequencer and output register of the sort-unique list core.
// ----------------------------------------------------------------------------
module sul_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                last_i,
  output logic                in_stall_o,
  input  logic                full_i,
  input  logic                head_valid_i,
  input  sul_pkg::value_t     head_value_i,
  input  logic                second_valid_i,
  input  sul_pkg::value_t     second_value_i,
  output sul_pkg::chain_cmd_t cmd_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sul_pkg::value_t     value_res_o,
  output logic                last_res_o,
  output logic                overflow_o
);

  sul_pkg::state_e state_q, state_d;
  logic            overflow_q, overflow_d;
  logic            out_valid_q, out_valid_d;
  sul_pkg::value_t out_value_q;
  logic            out_last_q, out_ovf_q;
  logic            accept, step, emit;

  // input is stalled in every state but loading
  assign accept = in_valid_i && (state_q == sul_pkg::ST_LOAD);
  // output register free this cycle
  assign step   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sul_pkg::ST_LOAD: begin
        if (accept && last_i) begin
          state_d = sul_pkg::ST_DRAIN;
        end
      end
      sul_pkg::ST_DRAIN: begin
        if (!head_valid_i) begin
          state_d = sul_pkg::ST_LOAD;
        end
      end
      default: state_d = sul_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_stall_o   = 1'b0;
    cmd_o.insert = 1'b0;
    cmd_o.shift  = 1'b0;
    emit         = 1'b0;
    overflow_d   = overflow_q;
    unique case (state_q)
      sul_pkg::ST_LOAD: begin
        cmd_o.insert = accept && !full_i;
        if (accept && full_i) begin
          overflow_d = 1'b1;
        end
      end
      sul_pkg::ST_DRAIN: begin
        in_stall_o  = 1'b1;
        cmd_o.shift = head_valid_i && step;
        // only the last copy of a run of equal values goes out
        emit        = head_valid_i && step &&
                      (!second_valid_i || (second_value_i != head_value_i));
        if (!head_valid_i) begin
          overflow_d = 1'b0;
        end
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sul_pkg::ST_LOAD;
      overflow_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      overflow_q  <= overflow_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q <= head_value_i;
      out_last_q  <= !second_valid_i;
      out_ovf_q   <= overflow_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_res_o = out_value_q;
  assign last_res_o  = out_last_q;
  assign overflow_o  = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_cmd_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.insert && cmd_o.shift))
    else $error("insert and shift in the same cycle");

  a_ovf_from_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(overflow_q) |-> $past(full_i) && $past(accept))
    else $error("overflow set without a transfer into a full chain");

  a_last_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !second_valid_i) |=> !head_valid_i)
    else $error("chain not empty after final result");

  a_no_emit_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sul_pkg::ST_LOAD) |-> !emit && !cmd_o.shift)
    else $error("drain activity while loading");
`endif

endmodule

/* test/sort_unique_list_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sort_unique_list_checker
// Watches both channels of the sort-unique core and checks every result.
// ----------------------------------------------------------------------------
// Each input transfer is inserted into a sorted shadow list; those beyond
// CAPACITY are dropped. The transfer marked last turns the list into its
// distinct values, ascending, which are queued as expected results. Each
// output transfer is compared with the oldest queued result, per field.
// ----------------------------------------------------------------------------
module sort_unique_list_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  sul_pkg::value_t value_i,
  input  logic            last_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  sul_pkg::value_t value_res_i,
  input  logic            last_res_i,
  input  logic            overflow_i,
  output int              fail_count_o,
  output int              pending_o
);

  typedef struct packed {
    sul_pkg::value_t value;
    logic            last;
    logic            overflow;
  } id_result_t;

  sul_pkg::value_t held_ids_q[$];
  logic            ids_dropped;
  id_result_t      distinct_ids_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $realtime, msg);
    fail_count_o++;
  endtask

  task automatic load_identifier(input sul_pkg::value_t v, input logic is_last);
    int              pos;
    sul_pkg::value_t top_id;
    logic            have_prev;
    sul_pkg::value_t prev;
    id_result_t      res;
    if (held_ids_q.size() >= sul_pkg::CAPACITY) begin
      ids_dropped = 1'b1;
    end else begin
      pos = held_ids_q.size();
      while (pos > 0 && held_ids_q[pos-1] > v) pos--;
      held_ids_q.insert(pos, v);
    end
    if (is_last) begin
      // list is sorted, so the final distinct value is the maximum
      top_id    = held_ids_q[held_ids_q.size()-1];
      have_prev = 1'b0;
      prev      = '0;
      foreach (held_ids_q[i]) begin
        if (!have_prev || held_ids_q[i] != prev) begin
          res.value    = held_ids_q[i];
          res.last     = (held_ids_q[i] == top_id);
          res.overflow = ids_dropped;
          distinct_ids_q.insert(distinct_ids_q.size(), res);
        end
        have_prev = 1'b1;
        prev      = held_ids_q[i];
      end
      held_ids_q.delete();
      ids_dropped = 1'b0;
    end
  endtask

  task automatic check_result();
    id_result_t want;
    if (distinct_ids_q.size() == 0) begin
      report_mismatch($sformatf("result %h with nothing expected", value_res_i));
    end else begin
      want = distinct_ids_q.pop_front();
      if (value_res_i !== want.value)
        report_mismatch($sformatf("value_res %h, want %h", value_res_i, want.value));
      if (last_res_i !== want.last)
        report_mismatch($sformatf("last_res %b, want %b (value %h)",
                                  last_res_i, want.last, want.value));
      if (overflow_i !== want.overflow)
        report_mismatch($sformatf("overflow %b, want %b (value %h)",
                                  overflow_i, want.overflow, want.value));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_ids_q.delete();
      distinct_ids_q.delete();
      ids_dropped = 1'b0;
      pending_o   = 0;
    end else begin
      if (in_valid_i && !in_stall_i) load_identifier(value_i, last_i);
      if (out_valid_i && !out_stall_i) check_result();
      pending_o = distinct_ids_q.size();
    end
  end

endmodule

/* test/sort_unique_list_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sort_unique_list_core_tb
// Stimulus and verdict for the sort-unique list core.
// ----------------------------------------------------------------------------
// Loads directed lists (extreme values, duplicates), then random lists, among
// them full and overflowing chains, under several idle and stall patterns. The
// checker beside the core predicts and compares; a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module sort_unique_list_core_tb;

  localparam int WatchdogLimit = 2000;

  logic            clk_i     = 1'b0;
  logic            rst_ni    = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_stall;
  sul_pkg::value_t in_value  = '0;
  logic            in_last   = 1'b0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  sul_pkg::value_t value_res;
  logic            last_res;
  logic            overflow;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  int phase_items;

  always #5 clk_i = ~clk_i;

  sort_unique_list_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .value_i     (in_value),
    .last_i      (in_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .value_res_o (value_res),
    .last_res_o  (last_res),
    .overflow_o  (overflow)
  );

  sort_unique_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .value_i      (in_value),
    .last_i       (in_last),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .value_res_i  (value_res),
    .last_res_i   (last_res),
    .overflow_i   (overflow),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // modes: full range, small range (many duplicates), near max, one hot
  function automatic sul_pkg::value_t gen_id(input int mode);
    sul_pkg::value_t v;
    case (mode)
      0:       v = $urandom;
      1:       v = $urandom_range(15);
      2:       v = 32'hFFFF_FFF0 | $urandom_range(15);
      default: v = 32'd1 << $urandom_range(31);
    endcase
    return v;
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input sul_pkg::value_t v, input logic is_last);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_value <= $urandom;
      in_last  <= 1'($urandom_range(1));
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_value <= v;
    in_last  <= is_last;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    phase_items++;
  endtask

  task automatic send_list(input int size, input int mode);
    for (int i = 0; i < size; i++) send_item(gen_id(mode), i == size - 1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-item lists at both ends of the range
    send_item(32'h0000_0000, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b1);
    // all duplicates collapse to one result
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b0);
    send_item(32'd7, 1'b1);
    // extremes mixed with duplicates
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);
    // already ascending, then descending
    send_item(32'd1, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd3, 1'b1);
    send_item(32'd3, 1'b0);
    send_item(32'd2, 1'b0);
    send_item(32'd1, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 75; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 75; end
        default: begin idle_pct = 21; stall_pct = 21; end
      endcase
      phase_items = 0;
      // full chain: exactly full, and overflow with the last three items dropped
      case (phase)
        2:       send_list(sul_pkg::CAPACITY, 1);
        3:       send_list(sul_pkg::CAPACITY + 3, 2);
        default: ;
      endcase
      phase_items = 0;
      while (phase_items < 15) send_list($urandom_range(1, 8), $urandom_range(3));
    end

    in_valid  <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (sul_pkg::CAPACITY + 8) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sort_unique_list_core.f */
design/sul_pkg.sv
design/sul_cell.sv
design/sul_ctrl.sv
design/sort_unique_list_core.sv
test/sort_unique_list_checker.sv
test/sort_unique_list_core_tb.sv
